### hw/rtl/pfr_pkg.sv
// Shared types and constants for the provisioning frame reassembler.
// No dependencies.
package pfr_pkg;

  localparam logic [7:0] ChPipe = 8'h7C;
  localparam logic [7:0] ChDash = 8'h2D;
  localparam logic [7:0] ChB    = 8'h42;
  localparam logic [7:0] ChM    = 8'h4D;
  localparam logic [7:0] Ch1    = 8'h31;
  localparam logic [7:0] Ch2    = 8'h32;
  localparam logic [7:0] Ch4    = 8'h34;
  localparam logic [7:0] Ch8    = 8'h38;
  localparam logic [7:0] Ch9    = 8'h39;
  localparam logic [7:0] ChA    = 8'h61;
  localparam logic [7:0] ChBl   = 8'h62;
  localparam logic [5:0] IdLen  = 6'd36;

  localparam logic [1:0] VerdictInvalid    = 2'd0;
  localparam logic [1:0] VerdictIncomplete = 2'd1;
  localparam logic [1:0] VerdictComplete   = 2'd2;

  localparam logic RegMaxFrame   = 1'b0;
  localparam logic RegMaxMessage = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } frame_word_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [7:0]  payload_byte;
    logic        version;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic        last_of_run;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic take_byte;   // absorb the accepted word
    logic emit_start;  // frame closed: settle verdict, start run
    logic emit_next;   // output word taken, advance run
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic run_more;    // more words of this run remain
  } dp_sts_t;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

endpackage

### hw/rtl/pfr_if.sv
// Valid/ready channel carrying a typed payload.
// Standalone; payload type is a parameter.
interface pfr_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/pfr_ctrl.sv
// Controller for the frame reassembler: accept, load and emit phases.
// Depends on pfr_pkg.
module pfr_ctrl
  import pfr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_eof_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  typedef enum logic [2:0] {
    StAccept = 3'b001,
    StLoad   = 3'b010,
    StEmit   = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_take;

  assign out_take    = out_valid_o && out_ready_i;
  assign out_valid_o = (state_q == StEmit);
  assign in_ready_o  = (state_q == StAccept);

  always_comb begin
    cmd_o            = '0;
    cmd_o.take_byte  = in_valid_i && in_ready_o;
    cmd_o.emit_start = cmd_o.take_byte && in_eof_i;
    cmd_o.emit_next  = out_take;
    state_d = state_q;
    unique case (state_q)
      StAccept: if (cmd_o.emit_start) state_d = StLoad;
      // the first payload word lands in the read register during this state
      StLoad: state_d = StEmit;
      StEmit: if (out_take && !sts_i.run_more) state_d = StAccept;
      default: state_d = StAccept;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StAccept;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/pfr_dp.sv
// Datapath: frame parser, session registers, message buffer and result register.
// Depends on pfr_pkg.
module pfr_dp
  import pfr_pkg::*;
#(
  parameter int MessageDepth = 64,
  parameter int FrameLimit   = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [9:0] cfg_data_i,
  input  logic [7:0] byte_i,
  input  dp_cmd_t    cmd_i,
  output dp_sts_t    sts_o,
  output result_t    res_o
);

  localparam int AW = $clog2(MessageDepth);
  localparam int LW = AW + 1;
  // The register tops out at 1023, so a larger build limit never binds.
  localparam int FrmCap = (FrameLimit < 1024) ? FrameLimit : 1024;
  localparam int FW = $clog2(FrmCap + 2);

  logic [9:0]  max_frame_q;
  logic [6:0]  max_msg_q;
  logic [2:0]  fnum_q, fnum_d;
  logic [5:0]  fpos_q, fpos_d;
  logic [FW-1:0] flen_q, flen_d;
  logic        fault_q, fault_d;
  logic        fver_q, fver_d;
  logic [127:0] fid_q, fid_d;
  logic [2:0]  fidx_q, fidx_d, fcnt_q, fcnt_d;
  logic [LW-1:0] fpay_q, fpay_d;
  logic        sval_q;
  logic        sver_q;
  logic [127:0] sid_q;
  logic [2:0]  scnt_q, snext_q;
  logic [LW-1:0] mlen_q;
  logic [7:0]  mem_q [MessageDepth];
  logic [7:0]  rd_q;
  logic [LW-1:0] rd_ptr_q;
  logic        run_q;
  result_t     res_q;

  logic [LW-1:0] base, pos;
  logic [LW:0]   msg_lim;
  logic [10:0]   frm_lim;
  logic          wr_en;
  logic [4:0]    hv;
  logic          ok;
  logic [LW-1:0] new_len;
  logic [AW-1:0] rd_addr;

  assign msg_lim = ({1'b0, max_msg_q} < 8'(MessageDepth)) ? (LW+1)'(max_msg_q)
                                                          : (LW+1)'(MessageDepth);
  assign frm_lim = ({1'b0, max_frame_q} < 11'(FrmCap)) ? {1'b0, max_frame_q}
                                                       : 11'(FrmCap);
  assign base = (fidx_q == 3'd1) ? '0 : mlen_q;
  assign pos  = base + fpay_q;
  assign hv   = hex_value(byte_i);
  // Read ahead so the next payload word is ready when the current one is taken.
  assign rd_addr = cmd_i.emit_next ? rd_ptr_q[AW-1:0] + 1'b1 : rd_ptr_q[AW-1:0];

  // Parse one word into the frame state.
  always_comb begin
    fnum_d = fnum_q; fpos_d = fpos_q; fault_d = fault_q; fver_d = fver_q;
    fid_d = fid_q; fidx_d = fidx_q; fcnt_d = fcnt_q; fpay_d = fpay_q;
    flen_d = (flen_q == FW'(FrmCap + 1)) ? flen_q : flen_q + 1'b1;
    wr_en = 1'b0;
    if (!fault_q) begin
      if (fnum_q < 3'd4) begin
        if (byte_i == ChPipe) begin
          if (fpos_q != ((fnum_q == 3'd0) ? 6'd3 : (fnum_q == 3'd1) ? IdLen : 6'd1))
            fault_d = 1'b1;
          fnum_d = fnum_q + 1'b1;
          fpos_d = '0;
          if (fnum_q == 3'd3 && !fault_d) begin
            if (fidx_q > fcnt_q) fault_d = 1'b1;
            else if (fidx_q != 3'd1 &&
                     (!sval_q || fver_q != sver_q || fid_q != sid_q ||
                      fcnt_q != scnt_q || fidx_q != snext_q))
              fault_d = 1'b1;
          end
        end else begin
          if (fpos_q < 6'd63) fpos_d = fpos_q + 1'b1;
          unique case (fnum_q)
            3'd0: begin
              if (fpos_q == 6'd0) begin
                if (byte_i != ChB) fault_d = 1'b1;
              end else if (fpos_q == 6'd1) begin
                if (byte_i != ChM) fault_d = 1'b1;
              end else if (fpos_q == 6'd2) begin
                if (byte_i == Ch1) fver_d = 1'b0;
                else if (byte_i == Ch2) fver_d = 1'b1;
                else fault_d = 1'b1;
              end else fault_d = 1'b1;
            end
            3'd1: begin
              if (fpos_q >= IdLen) fault_d = 1'b1;
              else if (fpos_q == 6'd8 || fpos_q == 6'd13 || fpos_q == 6'd18 ||
                       fpos_q == 6'd23) begin
                if (byte_i != ChDash) fault_d = 1'b1;
              end else begin
                if (fpos_q == 6'd14 && byte_i != Ch4) fault_d = 1'b1;
                if (fpos_q == 6'd19 && byte_i != Ch8 && byte_i != Ch9 &&
                    byte_i != ChA && byte_i != ChBl) fault_d = 1'b1;
                if (!hv[4]) fault_d = 1'b1;
                else fid_d = {fid_q[123:0], hv[3:0]};
              end
            end
            default: begin
              if (fpos_q != 6'd0 || byte_i < Ch1 || byte_i > Ch4) fault_d = 1'b1;
              else if (fnum_q == 3'd2) fidx_d = byte_i[2:0];
              else fcnt_d = byte_i[2:0];
            end
          endcase
        end
      end else begin
        if ((LW+1)'(pos) >= msg_lim) fault_d = 1'b1;
        else begin
          wr_en  = 1'b1;
          fpay_d = fpay_q + 1'b1;
        end
      end
    end
    ok = !fault_d && fnum_d == 3'd4 && fpay_d != '0 && 11'(flen_d) <= frm_lim;
    new_len = base + fpay_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && wr_en) mem_q[pos[AW-1:0]] <= byte_i;
    rd_q <= mem_q[rd_addr];
  end

  assign sts_o.run_more = run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= 10'd512; max_msg_q <= 7'd64;
      fnum_q <= '0; fpos_q <= '0; flen_q <= '0; fault_q <= 1'b0; fver_q <= 1'b0;
      fid_q <= '0; fidx_q <= '0; fcnt_q <= '0; fpay_q <= '0;
      sval_q <= 1'b0; sver_q <= 1'b0; sid_q <= '0; scnt_q <= '0;
      snext_q <= 3'd1; mlen_q <= '0; rd_ptr_q <= '0; run_q <= 1'b0;
      res_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegMaxFrame) max_frame_q <= cfg_data_i;
        else max_msg_q <= cfg_data_i[6:0];
      end
      if (cmd_i.take_byte) begin
        fnum_q <= fnum_d; fpos_q <= fpos_d; flen_q <= flen_d; fault_q <= fault_d;
        fver_q <= fver_d; fid_q <= fid_d; fidx_q <= fidx_d; fcnt_q <= fcnt_d;
        fpay_q <= fpay_d;
      end
      if (cmd_i.emit_start) begin
        fnum_q <= '0; fpos_q <= '0; flen_q <= '0; fault_q <= 1'b0; fver_q <= 1'b0;
        fid_q <= '0; fidx_q <= '0; fcnt_q <= '0; fpay_q <= '0;
        res_q <= '0;
        res_q.last_of_run <= 1'b1;
        run_q <= 1'b0;
        if (!ok) begin
          sval_q <= 1'b0; sver_q <= 1'b0; sid_q <= '0; scnt_q <= '0;
          snext_q <= 3'd1; mlen_q <= '0;
        end else begin
          logic       v;
          logic [127:0] id;
          logic [2:0] cnt;
          v   = (fidx_d == 3'd1) ? fver_d : sver_q;
          id  = (fidx_d == 3'd1) ? fid_d : sid_q;
          cnt = (fidx_d == 3'd1) ? fcnt_d : scnt_q;
          sval_q <= 1'b1; sver_q <= v; sid_q <= id; scnt_q <= cnt;
          mlen_q <= new_len;
          res_q.version <= v;
          res_q.id_high <= id[127:64];
          res_q.id_low  <= id[63:0];
          if (fidx_d < cnt) begin
            snext_q <= fidx_d + 1'b1;
            res_q.verdict <= VerdictIncomplete;
          end else begin
            // Payload run; first byte is read from memory next cycle.
            res_q.verdict <= VerdictComplete;
            res_q.last_of_run <= (new_len == LW'(1));
            run_q <= (new_len != LW'(1));
            rd_ptr_q <= '0;
            sval_q <= 1'b0; sver_q <= 1'b0; sid_q <= '0; scnt_q <= '0;
            snext_q <= 3'd1; mlen_q <= new_len;
          end
        end
      end
      if (cmd_i.emit_next && res_q.verdict == VerdictComplete) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
        res_q.last_of_run <= (rd_ptr_q + LW'(2) == mlen_q);
        run_q <= (rd_ptr_q + LW'(2) != mlen_q);
      end
    end
  end

  always_comb begin
    res_o = res_q;
    res_o.payload_byte = (res_q.verdict == VerdictComplete) ? rd_q : 8'd0;
  end

endmodule

### hw/rtl/provisioning_frame_reassembler.sv
// Provisioning frame reassembler, top level.
// Depends on pfr_pkg, pfr_if, pfr_ctrl, pfr_dp.
//
// Takes one frame word per cycle while no results are pending. Words without
// end of frame produce nothing. At each frame end one result is shown
// (invalid or incomplete) or, on the last frame of a message, one result per
// payload byte; input is held off while these results drain. The frame end
// is followed by a load state, in which the first payload byte is read from
// the store, and results then leave as fast as the output port takes them.
// The payload store is one write, one registered read port.
module provisioning_frame_reassembler
  import pfr_pkg::*;
#(
  parameter int MessageDepth = 64,
  parameter int FrameLimit   = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [9:0] cfg_data_i,
  pfr_if.sink        in_if,
  pfr_if.source      out_if
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  result_t res;

  pfr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_eof_i   (in_if.data.end_of_frame),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  pfr_dp #(.MessageDepth(MessageDepth), .FrameLimit(FrameLimit)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .byte_i (in_if.data.frame_byte),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res)
  );

  assign out_if.data = res;

endmodule

### hw/rtl/pfr_checker.sv
// Port-level checks for the provisioning frame reassembler.
// Depends on pfr_pkg; bound to the top level.
module pfr_checker
  import pfr_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("input open during run");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_inval_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.verdict == VerdictInvalid |->
      out_data.last_of_run && out_data.id_high == '0 && out_data.id_low == '0)
    else $error("invalid result carries data");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && out_data.last_of_run |=> !out_valid)
    else $error("run did not end");

endmodule

bind provisioning_frame_reassembler pfr_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid (in_if.valid), .in_ready (in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_data (out_if.data)
);

### tb/testbench.sv
// Self-checking testbench for provisioning_frame_reassembler.
// Depends on pfr_pkg and pfr_if. It drives frames byte by byte, predicts each
// frame-end run of results and compares every output word against that prediction.
module testbench;
  import pfr_pkg::*;

  typedef enum int {
    FrGood, FrBadProto, FrBadId, FrBadDigit, FrFewSep, FrEmpty, FrNoise
  } frame_kind_e;

  typedef struct {
    frame_kind_e kind;
    int          idx;
    int          cnt;
    int          plen;
    bit          new_msg;
    bit          exp_invalid;
  } frame_row_t;

  localparam int Depth    = 64;
  localparam int FrameCap = 512;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [9:0] cfg_data_i;

  pfr_if #(.T(frame_word_t)) in_if ();
  pfr_if #(.T(result_t))     out_if ();

  provisioning_frame_reassembler DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_if), .out_if(out_if)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  int          lim_frame;
  int          lim_msg;
  int          fld_num, fld_pos, frm_len, frm_idx, frm_cnt, frm_pay;
  bit          frm_fault, frm_ver;
  logic [63:0] frm_hi, frm_lo;
  bit          ses_valid, ses_ver;
  logic [63:0] ses_hi, ses_lo;
  int          ses_cnt, ses_next, msg_len;
  logic [7:0]  msg_buf [Depth];

  result_t     expected_q[$];
  int          mismatches;
  int          idle_mode;
  int          hold_cycles;
  byte         frame_bytes[$];
  logic [7:0]  uuid_chars[36];

  function automatic void clear_frame();
    fld_num = 0; fld_pos = 0; frm_len = 0; frm_fault = 0; frm_ver = 0;
    frm_hi = '0; frm_lo = '0; frm_idx = 0; frm_cnt = 0; frm_pay = 0;
  endfunction

  function automatic void clear_message();
    ses_valid = 0; ses_ver = 0; ses_hi = '0; ses_lo = '0;
    ses_cnt = 0; ses_next = 1; msg_len = 0;
  endfunction

  function automatic int eff_msg_limit();
    return lim_msg < Depth ? lim_msg : Depth;
  endfunction

  function automatic void parse_header(logic [7:0] c);
    int p;
    int need;
    int h;
    p = fld_pos;
    if (c == ChPipe) begin
      need = fld_num == 0 ? 3 : fld_num == 1 ? 36 : 1;
      if (p != need) frm_fault = 1;
      fld_num++;
      fld_pos = 0;
      if (fld_num == 4 && !frm_fault) begin
        if (frm_idx > frm_cnt) frm_fault = 1;
        else if (frm_idx != 1) begin
          if (!ses_valid || frm_ver != ses_ver || frm_hi != ses_hi || frm_lo != ses_lo ||
              frm_cnt != ses_cnt || frm_idx != ses_next)
            frm_fault = 1;
        end
      end
      return;
    end
    if (fld_pos < 63) fld_pos++;
    if (fld_num == 0) begin
      if (p == 0) begin
        if (c != ChB) frm_fault = 1;
      end else if (p == 1) begin
        if (c != ChM) frm_fault = 1;
      end else if (p == 2) begin
        if (c == Ch1) frm_ver = 0;
        else if (c == Ch2) frm_ver = 1;
        else frm_fault = 1;
      end else frm_fault = 1;
    end else if (fld_num == 1) begin
      if (p >= 36) begin
        frm_fault = 1;
        return;
      end
      if (p == 8 || p == 13 || p == 18 || p == 23) begin
        if (c != ChDash) frm_fault = 1;
        return;
      end
      if (p == 14 && c != Ch4) frm_fault = 1;
      if (p == 19 && c != Ch8 && c != Ch9 && c != ChA && c != ChBl) frm_fault = 1;
      if (c >= "0" && c <= "9") h = c - "0";
      else if (c >= "a" && c <= "f") h = c - "a" + 10;
      else h = -1;
      if (h < 0) begin
        frm_fault = 1;
        return;
      end
      frm_hi = {frm_hi[59:0], frm_lo[63:60]};
      frm_lo = {frm_lo[59:0], h[3:0]};
    end else begin
      if (p != 0 || c < Ch1 || c > Ch4) begin
        frm_fault = 1;
        return;
      end
      if (fld_num == 2) frm_idx = c - "0";
      else frm_cnt = c - "0";
    end
  endfunction

  function automatic void push_result(logic [1:0] v, logic [7:0] b, bit ver,
                                      logic [63:0] hi, logic [63:0] lo, bit last);
    result_t r;
    r.verdict = v; r.payload_byte = b; r.version = ver;
    r.id_high = hi; r.id_low = lo; r.last_of_run = last;
    expected_q.push_back(r);
  endfunction

  // absorb one accepted word and queue the results of a frame end
  function automatic void reassemble_word(logic [7:0] c, bit eof);
    int base;
    int pos;
    bit ok;
    if (frm_len < 'hFFFF) frm_len++;
    if (!frm_fault) begin
      if (fld_num < 4) parse_header(c);
      else begin
        base = frm_idx == 1 ? 0 : msg_len;
        pos = base + frm_pay;
        if (pos >= eff_msg_limit()) frm_fault = 1;
        else begin
          msg_buf[pos % Depth] = c;
          frm_pay++;
        end
      end
    end
    if (!eof) return;
    ok = !frm_fault && fld_num == 4 && frm_pay > 0 &&
         frm_len <= (lim_frame < FrameCap ? lim_frame : FrameCap);
    if (!ok) begin
      clear_message();
      push_result(VerdictInvalid, 8'h00, 0, '0, '0, 1);
    end else begin
      base = frm_idx == 1 ? 0 : msg_len;
      if (frm_idx == 1) begin
        ses_valid = 1; ses_ver = frm_ver; ses_hi = frm_hi; ses_lo = frm_lo;
        ses_cnt = frm_cnt;
      end
      msg_len = base + frm_pay;
      if (frm_idx < ses_cnt) begin
        ses_next = frm_idx + 1;
        push_result(VerdictIncomplete, 8'h00, ses_ver, ses_hi, ses_lo, 1);
      end else begin
        for (int i = 0; i < msg_len && i < Depth; i++)
          push_result(VerdictComplete, msg_buf[i], ses_ver, ses_hi, ses_lo,
                      i + 1 == msg_len);
        clear_message();
      end
    end
    clear_frame();
  endfunction

  function automatic void new_uuid();
    logic [7:0] hexd[16];
    hexd = '{"0","1","2","3","4","5","6","7","8","9","a","b","c","d","e","f"};
    for (int i = 0; i < 36; i++) uuid_chars[i] = hexd[$urandom_range(0, 15)];
    uuid_chars[8] = ChDash; uuid_chars[13] = ChDash;
    uuid_chars[18] = ChDash; uuid_chars[23] = ChDash;
    uuid_chars[14] = Ch4;
    uuid_chars[19] = hexd[$urandom_range(8, 11)];
  endfunction

  // build one frame's bytes into frame_bytes
  function automatic void build_frame(frame_kind_e kind, bit ver, int idx, int cnt, int plen);
    frame_bytes.delete();
    if (kind == FrNoise) begin
      for (int i = 0; i < plen; i++) frame_bytes.push_back($urandom_range(0, 255));
      return;
    end
    frame_bytes.push_back(kind == FrBadProto ? "b" : ChB);
    frame_bytes.push_back(ChM);
    frame_bytes.push_back(ver ? Ch2 : Ch1);
    frame_bytes.push_back(ChPipe);
    for (int i = 0; i < 36; i++) frame_bytes.push_back(uuid_chars[i]);
    if (kind == FrBadId) frame_bytes[4 + $urandom_range(0, 35)] = "G";
    frame_bytes.push_back(ChPipe);
    frame_bytes.push_back(kind == FrBadDigit ? "5" : "0" + idx);
    frame_bytes.push_back(ChPipe);
    frame_bytes.push_back("0" + cnt);
    if (kind != FrFewSep) frame_bytes.push_back(ChPipe);
    if (kind != FrEmpty)
      for (int i = 0; i < plen; i++)
        frame_bytes.push_back($urandom_range(0, 7) == 0 ? ChPipe : $urandom_range(0, 255));
    // keep the missing separator missing
    if (kind == FrFewSep && plen > 0 && frame_bytes[44] == ChPipe) frame_bytes[44] = "x";
  endfunction

  function automatic bit sender_gap();
    if (idle_mode == 1) return $urandom_range(0, 99) < 76;
    if (idle_mode == 3) return $urandom_range(0, 99) < 23;
    return 0;
  endfunction

  task automatic send_word(logic [7:0] b, bit eof);
    @(negedge clk_i);
    while (sender_gap()) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{frame_byte: b, end_of_frame: eof};
    do @(posedge clk_i); while (!in_if.ready);
    reassemble_word(b, eof);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_word(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, int value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= value[9:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegMaxFrame) lim_frame = value & 'h3FF;
    else lim_msg = value & 'h7F;
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else if (idle_mode == 2) out_if.ready <= $urandom_range(0, 99) >= 76;
    else if (idle_mode == 3) out_if.ready <= $urandom_range(0, 99) >= 23;
    else out_if.ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_if.data);
      end else begin
        result_t e;
        e = expected_q.pop_front();
        if (e.verdict !== out_if.data.verdict || e.payload_byte !== out_if.data.payload_byte ||
            e.version !== out_if.data.version || e.id_high !== out_if.data.id_high ||
            e.id_low !== out_if.data.id_low || e.last_of_run !== out_if.data.last_of_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", e, out_if.data);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("provisioning_frame_reassembler verification failed");
    $finish;
  end

  initial begin
    frame_row_t rows[$];
    int words_sent;
    bit ver;
    in_if.valid = 1'b0; in_if.data = '0; out_if.ready = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = RegMaxFrame; cfg_data_i = '0;
    hold_cycles = 0; idle_mode = 0; mismatches = 0;
    lim_frame = 512; lim_msg = 64;
    ver = 1'b0;
    clear_frame(); clear_message();
    foreach (msg_buf[i]) msg_buf[i] = 8'h00;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // kind, index, count, payload length, new id, expect invalid
    rows = '{
      '{FrGood,     1, 2, 2,  1, 0},
      '{FrGood,     2, 2, 1,  0, 0},  // closes a two-frame message
      '{FrGood,     2, 2, 1,  0, 1},  // no open message
      '{FrNoise,    1, 1, 3,  1, 1}
    };
    foreach (rows[r]) begin
      if (rows[r].new_msg) begin
        new_uuid();
        ver = $urandom_range(0, 1);
      end
      build_frame(rows[r].kind, ver, rows[r].idx, rows[r].cnt, rows[r].plen);
      if (rows[r].kind == FrNoise) frame_bytes.push_back(8'hFF);
      send_frame();
      // the frame's results were queued at its last word, after earlier runs drained
      if (rows[r].exp_invalid && expected_q[$].verdict != VerdictInvalid) begin
        mismatches++;
        if (mismatches <= 10) $display("frame row %0d not predicted invalid", r);
      end
    end
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(RegMaxFrame, 'h3FF); write_reg(RegMaxMessage, 'h7F); end
        1: begin write_reg(RegMaxFrame, 60);    write_reg(RegMaxMessage, 20);   end
        2: begin write_reg(RegMaxFrame, 512);   write_reg(RegMaxMessage, 64);   end
        3: begin write_reg(RegMaxFrame, 0);     write_reg(RegMaxMessage, 0);    end
        default: begin write_reg(RegMaxFrame, 90); write_reg(RegMaxMessage, 1); end
      endcase
      idle_mode = ph % 4;
      if (ph == 2) hold_cycles = 400;
      words_sent = 0;
      while (words_sent < 8) begin
        build_frame(FrNoise, 1'b0, 1, 1, $urandom_range(1, 3));
        words_sent += frame_bytes.size();
        send_frame();
      end
      drain();
    end

    if (mismatches == 0 && expected_q.size() == 0)
      $display("provisioning_frame_reassembler verification clean");
    else
      $display("provisioning_frame_reassembler verification failed");
    $finish;
  end

endmodule
